// ===== rtl/core/sirf_pkg.sv =====
// Shared types, constants and helpers for the signed integer radix formatter.
package sirf_pkg;

  localparam int VALUE_W     = 32;
  localparam int SYM_W       = 8;
  localparam int COUNT_W     = 6;
  localparam int ALPHA_SYMS  = 32;
  localparam int ALPHA_W     = ALPHA_SYMS * SYM_W;
  localparam int SYM_IDX_W   = $clog2(ALPHA_SYMS);
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;

  // Divider retires this many quotient bits per cycle.
  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam int DEF_MAX_SYMBOLS = 32;
  localparam int DEF_DIGIT_SLOTS = 32;

  localparam logic [SYM_W-1:0]   CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0]   CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   CHAR_LO    = 8'd32;
  localparam logic [SYM_W-1:0]   CHAR_HI    = 8'd126;
  localparam logic [COUNT_W-1:0] MIN_RADIX  = 6'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_WORD1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_WORD2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_WORD3  = 3'd4;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [ALPHA_W-1:0] alpha;
  } sirf_cfg_t;

  typedef struct packed {
    logic cnt_ok;
    logic sym_bad;
  } sirf_chk_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                               input logic [SYM_IDX_W-1:0] k);
    return alpha[{k, 3'b000} +: SYM_W];
  endfunction

endpackage

// ===== rtl/core/sirf_cfg_regs.sv =====
// APB register file: symbol count and the four alphabet words.
module sirf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sirf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sirf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sirf_pkg::CFG_DATA_W-1:0] prdata,
  output sirf_pkg::sirf_cfg_t             cfg
);

  logic [sirf_pkg::COUNT_W-1:0]    count_r;
  logic [sirf_pkg::CFG_DATA_W-1:0] word_r [4];
  logic [sirf_pkg::CFG_IDX_W-1:0]  idx;
  logic                            wr_en;

  assign idx   = paddr[sirf_pkg::CFG_ADDR_W-1:3];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < 4; i++) word_r[i] <= '0;
    end else if (wr_en) begin
      unique case (idx)
        sirf_pkg::REG_SYMBOL_COUNT: count_r   <= pwdata[sirf_pkg::COUNT_W-1:0];
        sirf_pkg::REG_ALPHA_WORD0:  word_r[0] <= pwdata;
        sirf_pkg::REG_ALPHA_WORD1:  word_r[1] <= pwdata;
        sirf_pkg::REG_ALPHA_WORD2:  word_r[2] <= pwdata;
        sirf_pkg::REG_ALPHA_WORD3:  word_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sirf_pkg::REG_SYMBOL_COUNT:
        prdata = {{(sirf_pkg::CFG_DATA_W-sirf_pkg::COUNT_W){1'b0}}, count_r};
      sirf_pkg::REG_ALPHA_WORD0: prdata = word_r[0];
      sirf_pkg::REG_ALPHA_WORD1: prdata = word_r[1];
      sirf_pkg::REG_ALPHA_WORD2: prdata = word_r[2];
      sirf_pkg::REG_ALPHA_WORD3: prdata = word_r[3];
      default:                   prdata = '0;
    endcase
  end

  assign cfg.count = count_r;
  assign cfg.alpha = {word_r[3], word_r[2], word_r[1], word_r[0]};

endmodule

// ===== rtl/core/sirf_alpha_chk.sv =====
// Alphabet check for one symbol: legal byte, no later duplicate; plus count range.
module sirf_alpha_chk #(
  parameter int MaxSymbols = sirf_pkg::DEF_MAX_SYMBOLS
) (
  input  sirf_pkg::sirf_cfg_t             cfg,
  input  logic [$clog2(MaxSymbols)-1:0]   idx,
  output sirf_pkg::sirf_chk_t             chk
);

  logic [sirf_pkg::SYM_W-1:0] cur;
  logic                       dup;

  assign cur = sirf_pkg::sym_at(cfg.alpha, sirf_pkg::SYM_IDX_W'(idx));

  always_comb begin
    dup = 1'b0;
    for (int b = 0; b < MaxSymbols; b++) begin
      if (sirf_pkg::COUNT_W'(b) > sirf_pkg::COUNT_W'(idx) &&
          sirf_pkg::COUNT_W'(b) < cfg.count &&
          sirf_pkg::sym_at(cfg.alpha, sirf_pkg::SYM_IDX_W'(b)) == cur)
        dup = 1'b1;
    end
  end

  assign chk.sym_bad = dup || cur == sirf_pkg::CHAR_MINUS || cur == sirf_pkg::CHAR_PLUS ||
                       cur < sirf_pkg::CHAR_LO || cur > sirf_pkg::CHAR_HI;
  assign chk.cnt_ok  = cfg.count >= sirf_pkg::MIN_RADIX &&
                       cfg.count <= sirf_pkg::COUNT_W'(MaxSymbols);

endmodule

// ===== rtl/core/sirf_div_step.sv =====
// Restoring divide by the radix, DIV_BITS quotient bits per use.
module sirf_div_step (
  input  logic [sirf_pkg::COUNT_W-1:0]  rem_in,
  input  logic [sirf_pkg::DIV_BITS-1:0] bits_in,
  input  logic [sirf_pkg::COUNT_W-1:0]  radix,
  output logic [sirf_pkg::COUNT_W-1:0]  rem_out,
  output logic [sirf_pkg::DIV_BITS-1:0] quot
);

  always_comb begin
    logic [sirf_pkg::COUNT_W:0] r;
    r = {1'b0, rem_in};
    for (int i = sirf_pkg::DIV_BITS - 1; i >= 0; i--) begin
      r = {r[sirf_pkg::COUNT_W-1:0], bits_in[i]};
      if (r >= {1'b0, radix}) begin
        r       = r - {1'b0, radix};
        quot[i] = 1'b1;
      end else begin
        quot[i] = 1'b0;
      end
    end
    rem_out = r[sirf_pkg::COUNT_W-1:0];
  end

endmodule

// ===== rtl/core/signed_integer_radix_formatter.sv =====
// Top level: signed 32-bit integer to text in a configured radix and alphabet.
//
// in_*  : one word per value, in_tdata = value (two's complement).
// out_* : one word per symbol, most significant first, '-' first for negatives;
//         out_tlast marks the final symbol of a value. An invalid alphabet
//         or symbol count yields no words for that value.
// cfg_* : APB, 64-bit data, register i at byte address 8*i, pready always high.
// Per value: an accept step, a check of each of the symbol_count symbols (one
// symbol a cycle through the alphabet checker), then each digit in the shared
// 8-bit-per-cycle divider, a step to prime the digit buffer read, then one
// symbol per cycle while the receiver is ready.
// in_tready is high only while idle; the final symbol may still sit in the
// output register while the next value is taken. A stalled receiver holds the
// output register and pauses symbol emission. Reset clears the config registers
// to 0, the sequencer to idle and drops out_tvalid.
module signed_integer_radix_formatter #(
  parameter int MaxSymbols = sirf_pkg::DEF_MAX_SYMBOLS,
  parameter int DigitSlots = sirf_pkg::DEF_DIGIT_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sirf_pkg::VALUE_W-1:0]    in_tdata,    // [31:0] value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sirf_pkg::SYM_W-1:0]      out_tdata,   // [7:0] symbol
  output logic                            out_tlast,   // last
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sirf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sirf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sirf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int DIG_W  = $clog2(MaxSymbols);
  localparam int SLOT_W = $clog2(DigitSlots);
  localparam int CNT_W  = $clog2(DigitSlots + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_PREP, ST_EMIT} state_t;

  sirf_pkg::sirf_cfg_t cfg;
  sirf_pkg::sirf_chk_t chk;

  state_t                          state_r;
  logic [DIG_W-1:0]                chk_idx_r;
  logic [sirf_pkg::VALUE_W-1:0]    mag_r;
  logic [sirf_pkg::COUNT_W-1:0]    rem_r;
  logic [sirf_pkg::STEP_W-1:0]     step_r;
  logic [CNT_W-1:0]                nd_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            sign_r;
  logic                            out_tvalid_r;
  logic [sirf_pkg::SYM_W-1:0]      out_sym_r;
  logic                            out_last_r;

  logic [DIG_W-1:0]                digits_r [DigitSlots];
  logic [DIG_W-1:0]                rd_r;
  logic [SLOT_W-1:0]               rd_addr;

  logic [sirf_pkg::COUNT_W-1:0]    rem_out;
  logic [sirf_pkg::DIV_BITS-1:0]   quot;
  logic [sirf_pkg::VALUE_W-1:0]    mag_shift;
  logic [CNT_W-1:0]                nd_inc;
  logic                            digit_done;
  logic                            load;
  logic                            in_fire;

  sirf_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  sirf_alpha_chk #(.MaxSymbols(MaxSymbols)) u_chk (
    .cfg (cfg),
    .idx (chk_idx_r),
    .chk (chk)
  );

  sirf_div_step u_div (
    .rem_in  (rem_r),
    .bits_in (mag_r[sirf_pkg::VALUE_W-1 -: sirf_pkg::DIV_BITS]),
    .radix   (cfg.count),
    .rem_out (rem_out),
    .quot    (quot)
  );

  assign cfg_pready = 1'b1;
  assign in_tready  = state_r == ST_IDLE;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

  assign mag_shift  = {mag_r[sirf_pkg::VALUE_W-sirf_pkg::DIV_BITS-1:0], quot};
  assign nd_inc     = nd_r + CNT_W'(1);
  assign digit_done = step_r == sirf_pkg::STEP_W'(sirf_pkg::DIV_STEPS - 1);
  assign load       = !out_tvalid_r || out_tready;

  // Digits come out in reverse; prefetch the next one when a digit is consumed.
  always_comb begin
    if (state_r == ST_EMIT && load && !sign_r) rd_addr = SLOT_W'(cnt_r - CNT_W'(2));
    else                                       rd_addr = SLOT_W'(cnt_r - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && digit_done) digits_r[nd_r[SLOT_W-1:0]] <= rem_out[DIG_W-1:0];
    rd_r <= digits_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == ST_EMIT && load) out_tvalid_r <= 1'b1;
      else if (out_tready)            out_tvalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sign_r    <= in_tdata[sirf_pkg::VALUE_W-1];
            mag_r     <= in_tdata[sirf_pkg::VALUE_W-1] ?
                         (~in_tdata + sirf_pkg::VALUE_W'(1)) : in_tdata;
            chk_idx_r <= '0;
            state_r   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!chk.cnt_ok || chk.sym_bad) begin
            state_r <= ST_IDLE;
          end else if (sirf_pkg::COUNT_W'(chk_idx_r) == cfg.count - sirf_pkg::COUNT_W'(1)) begin
            rem_r   <= '0;
            step_r  <= '0;
            nd_r    <= '0;
            state_r <= ST_DIV;
          end else begin
            chk_idx_r <= chk_idx_r + DIG_W'(1);
          end
        end
        ST_DIV: begin
          mag_r  <= mag_shift;
          rem_r  <= digit_done ? '0 : rem_out;
          step_r <= step_r + sirf_pkg::STEP_W'(1);
          if (digit_done) begin
            nd_r  <= nd_inc;
            if (mag_shift == '0 || nd_inc == CNT_W'(DigitSlots)) begin
              cnt_r   <= nd_inc;
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (load) begin
            if (sign_r) begin
              out_sym_r  <= sirf_pkg::CHAR_MINUS;
              out_last_r <= 1'b0;
              sign_r     <= 1'b0;
            end else begin
              out_sym_r  <= sirf_pkg::sym_at(cfg.alpha, sirf_pkg::SYM_IDX_W'(rd_r));
              out_last_r <= cnt_r == CNT_W'(1);
              cnt_r      <= cnt_r - CNT_W'(1);
              if (cnt_r == CNT_W'(1)) state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken while a value is in progress");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> cnt_r != '0)
    else $error("emitting with no digits left");

  a_digit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> nd_r < CNT_W'(DigitSlots))
    else $error("digit buffer overrun");

  a_rem_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == '0) |-> rem_r == '0)
    else $error("divider remainder not cleared at digit start");

endmodule
